### rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, scale constants and helpers for the IMU sample calibrator.
// ----------------------------------------------------------------------------
package isc_pkg;

    localparam int RAW_W      = 16;
    localparam int OUT_W      = 32;
    localparam int SCALE_FRAC = 40;
    localparam int KW         = 41;           // signed width of a scale factor
    localparam int PW         = RAW_W + KW;   // raw * scale product
    localparam int BIAS_W     = 25;
    localparam int CFG_IDX_W  = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Z = 2'd2;

    // scale factors with SCALE_FRAC fraction bits
    localparam longint K_ACC_L  = 64'sd1 <<< (SCALE_FRAC - 14);
    localparam longint K_GYRO_L = ((64'sd1 <<< SCALE_FRAC) + 64'sd65) / 64'sd131;
    localparam longint K_TEMP_L = ((64'sd1 <<< SCALE_FRAC) + 64'sd170) / 64'sd340;
    localparam longint K_MAG_L  = (64'sd73 * (64'sd1 <<< SCALE_FRAC) + 64'sd50) / 64'sd100;

    localparam logic signed [KW-1:0] K_ACC  = KW'(K_ACC_L);
    localparam logic signed [KW-1:0] K_GYRO = KW'(K_GYRO_L);
    localparam logic signed [KW-1:0] K_TEMP = KW'(K_TEMP_L);
    localparam logic signed [KW-1:0] K_MAG  = KW'(K_MAG_L);

    // magnetometer overflow code
    localparam logic signed [RAW_W-1:0] MAG_OVF = -16'sd4096;

    // offsets and coefficients in millionths, row-major matrices
    localparam longint ACC_OFF_U [3] = '{64'sd19400, -64'sd8463, -64'sd98649};
    localparam longint ACC_MAT_U [9] = '{
        64'sd991896,  64'sd922,      -64'sd2850,
        64'sd922,     64'sd1004652,  -64'sd2416,
        -64'sd2850,   -64'sd2416,    64'sd984773
    };
    localparam longint MAG_OFF_U [3] = '{-64'sd187279956, 64'sd7723305, -64'sd57187};
    localparam longint MAG_MAT_U [9] = '{
        64'sd875656,  64'sd27110,    -64'sd54459,
        64'sd27110,   64'sd891379,   64'sd14806,
        -64'sd54459,  64'sd14806,    64'sd963926
    };
    localparam longint TEMP_OFF_U = 64'sd36530000;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    typedef logic [2:0][RAW_W-1:0] t_raw3;
    typedef logic [2:0][OUT_W-1:0] t_q3;

    // millionths to fixed point with f fraction bits, nearest, ties away from zero
    function automatic longint rndq(input longint m, input int f);
        longint a;
        a = (m < 0) ? -m : m;
        a = (a * (64'sd1 <<< f) + 64'sd500000) / 64'sd1000000;
        return (m < 0) ? -a : a;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/isc_cal3.sv
// ----------------------------------------------------------------------------
// isc_cal3
// Three-axis calibration pipe: scale, subtract offset, saturate, 3x3 matrix.
// ----------------------------------------------------------------------------
module isc_cal3 #(
    parameter int FRAC_BITS      = 16,
    parameter int COEF_FRAC_BITS = 20,
    parameter bit IS_MAG         = 1'b0
) (
    input  logic              i_clk,
    input  isc_pkg::t_pipe_en i_en,
    input  isc_pkg::t_raw3    i_raw,    // x, y, z from the lowest bits up
    input  logic              i_keep,
    output isc_pkg::t_q3      o_res     // x, y, z from the lowest bits up
);
    import isc_pkg::*;

    localparam int SH   = SCALE_FRAC - FRAC_BITS;
    localparam int SW   = PW + 1;
    localparam int CW   = COEF_FRAC_BITS + 2;
    localparam int MW   = OUT_W + CW;
    localparam int SUMW = MW + 2;

    localparam logic signed [KW-1:0] K = IS_MAG ? K_MAG : K_ACC;

    logic signed [PW-1:0]    r_prod [3];
    logic signed [OUT_W-1:0] r_t    [3];
    logic signed [MW-1:0]    r_mul  [3][3];
    t_q3                     r_res;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        localparam logic signed [SW-1:0] OFF =
            SW'(rndq(IS_MAG ? MAG_OFF_U[i] : ACC_OFF_U[i], FRAC_BITS));

        logic signed [SW-1:0]    scaled;
        logic signed [SW-1:0]    diff;
        logic signed [SUMW-1:0]  sum;
        logic signed [SUMW-1:0]  rnd;
        logic signed [OUT_W-1:0] n_t;

        // stage 1: raw * scale
        always_ff @(posedge i_clk) begin
            if (i_en.s1) begin
                r_prod[i] <= $signed(i_raw[i]) * K;
            end
        end

        // stage 2: round to FRAC_BITS, remove offset, saturate
        always_comb begin
            scaled = (SW'(r_prod[i]) + (SW'(1) <<< (SH - 1))) >>> SH;
            diff   = scaled - OFF;
            n_t    = sat32(64'(diff));
        end

        always_ff @(posedge i_clk) begin
            if (i_en.s2) begin
                r_t[i] <= n_t;
            end
        end

        // stage 3: one row of the matrix
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam logic signed [CW-1:0] COEF =
                CW'(rndq(IS_MAG ? MAG_MAT_U[3*i+j] : ACC_MAT_U[3*i+j], COEF_FRAC_BITS));

            always_ff @(posedge i_clk) begin
                if (i_en.s3) begin
                    r_mul[i][j] <= MW'(r_t[j]) * MW'(COEF);
                end
            end
        end

        // stage 4: sum the row, round, saturate; zero an invalid group
        always_comb begin
            sum = SUMW'(r_mul[i][0]) + SUMW'(r_mul[i][1]) + SUMW'(r_mul[i][2]);
            rnd = (sum + (SUMW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        end

        always_ff @(posedge i_clk) begin
            if (i_en.s4) begin
                r_res[i] <= i_keep ? sat32(64'(rnd)) : '0;
            end
        end
    end

    assign o_res = r_res;

endmodule

### rtl/imu_sample_calibrator.sv
// ----------------------------------------------------------------------------
// imu_sample_calibrator
// Raw IMU frames in, calibrated Q-format acceleration, rate, field and
// temperature out.
//
//   channel   direction  handshake                 payload
//   s         in         i_s_tvalid / o_s_tready   raw frame, read-ok flags
//   m         out        o_m_tvalid / i_m_tready   calibrated frame, valid flags
//   cfg       in         i_cfg_we                  gyro bias x, y, z
//
// Four register stages (scale product, offset and saturate, matrix products,
// row sum and round); one frame is taken every cycle unless a full pipe stalls.
// The stage valid bits are cleared by reset, as are the gyro biases.
// A stall at the output holds the last stage; empty stages further up keep
// filling, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module imu_sample_calibrator #(
    parameter int FRAC_BITS      = 16,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // acc_raw_x, acc_raw_y, acc_raw_z, rate_raw_x, rate_raw_y, rate_raw_z,
    // temp_raw, field_raw_first, field_raw_second, field_raw_third
    input  logic [159:0]                   i_s_tdata,
    // motion_read_ok, field_read_ok
    input  logic [1:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, field_x, field_y, field_z,
    // temperature
    output logic [319:0]                   o_m_tdata,
    // motion_valid, field_valid
    output logic [1:0]                     o_m_tuser,
    input  logic                           i_cfg_we,
    input  logic [isc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [isc_pkg::BIAS_W-1:0]     i_cfg_wdata
);
    import isc_pkg::*;

    localparam int SH = SCALE_FRAC - FRAC_BITS;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] TEMP_OFF = SW'(rndq(TEMP_OFF_U, FRAC_BITS));

    t_pipe_en en;
    logic     r_v1, r_v2, r_v3, r_v4;
    logic     r_mok1, r_mok2, r_mok3, r_mok4;
    logic     r_fok1, r_fok2, r_fok3, r_fok4;

    logic [BIAS_W-1:0] r_bias [3];

    t_raw3 acc_raw;
    t_raw3 mag_raw;
    t_q3   acc_res;
    t_q3   mag_res;
    logic  fld_ok;

    logic signed [PW-1:0]    r_rate_p [3];
    logic signed [PW-1:0]    r_temp_p;
    logic signed [OUT_W-1:0] r_rate2 [3];
    logic signed [OUT_W-1:0] r_rate3 [3];
    logic signed [OUT_W-1:0] r_rate4 [3];
    logic signed [OUT_W-1:0] r_temp2, r_temp3, r_temp4;
    logic signed [SW-1:0]    temp_scaled;

    // a stage advances when it is empty or the one below advances
    always_comb begin
        en.s4 = !r_v4 || i_m_tready;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign o_s_tready = en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_s_tvalid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias[0] <= '0;
            r_bias[1] <= '0;
            r_bias[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GYRO_BIAS_X: r_bias[0] <= i_cfg_wdata;
                REG_GYRO_BIAS_Y: r_bias[1] <= i_cfg_wdata;
                REG_GYRO_BIAS_Z: r_bias[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // magnetometer words arrive as x, z, y
    always_comb begin
        acc_raw[0] = i_s_tdata[15:0];
        acc_raw[1] = i_s_tdata[31:16];
        acc_raw[2] = i_s_tdata[47:32];
        mag_raw[0] = i_s_tdata[127:112];
        mag_raw[1] = i_s_tdata[159:144];
        mag_raw[2] = i_s_tdata[143:128];
        fld_ok = i_s_tuser[1]
            && ($signed(i_s_tdata[127:112]) != MAG_OVF)
            && ($signed(i_s_tdata[143:128]) != MAG_OVF)
            && ($signed(i_s_tdata[159:144]) != MAG_OVF);
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_mok1 <= i_s_tuser[0];
            r_fok1 <= fld_ok;
        end
        if (en.s2) begin
            r_mok2 <= r_mok1;
            r_fok2 <= r_fok1;
        end
        if (en.s3) begin
            r_mok3 <= r_mok2;
            r_fok3 <= r_fok2;
        end
        if (en.s4) begin
            r_mok4 <= r_mok3;
            r_fok4 <= r_fok3;
        end
    end

    // gyro: scale, remove bias, saturate, then ride along to the output
    for (genvar i = 0; i < 3; i++) begin : g_rate
        logic signed [SW-1:0] scaled;
        logic signed [SW-1:0] diff;

        always_comb begin
            scaled = (SW'(r_rate_p[i]) + (SW'(1) <<< (SH - 1))) >>> SH;
            diff   = scaled - SW'($signed(r_bias[i]));
        end

        always_ff @(posedge i_clk) begin
            if (en.s1) r_rate_p[i] <= $signed(i_s_tdata[48+16*i +: 16]) * K_GYRO;
            if (en.s2) r_rate2[i] <= sat32(64'(diff));
            if (en.s3) r_rate3[i] <= r_rate2[i];
            if (en.s4) r_rate4[i] <= r_mok3 ? r_rate3[i] : '0;
        end
    end

    assign temp_scaled = (SW'(r_temp_p) + (SW'(1) <<< (SH - 1))) >>> SH;

    always_ff @(posedge i_clk) begin
        if (en.s1) r_temp_p <= $signed(i_s_tdata[111:96]) * K_TEMP;
        if (en.s2) r_temp2 <= sat32(64'(temp_scaled + TEMP_OFF));
        if (en.s3) r_temp3 <= r_temp2;
        if (en.s4) r_temp4 <= r_mok3 ? r_temp3 : '0;
    end

    isc_cal3 #(
        .FRAC_BITS      (FRAC_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .IS_MAG         (1'b0)
    ) u_acc (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_raw  (acc_raw),
        .i_keep (r_mok3),
        .o_res  (acc_res)
    );

    isc_cal3 #(
        .FRAC_BITS      (FRAC_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .IS_MAG         (1'b1)
    ) u_mag (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_raw  (mag_raw),
        .i_keep (r_fok3),
        .o_res  (mag_res)
    );

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {r_temp4, mag_res, r_rate4[2], r_rate4[1], r_rate4[0], acc_res};
    assign o_m_tuser  = {r_fok4, r_mok4};

`ifndef SYNTHESIS
    // ready drops only when every stage holds a frame and the output stalls
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !i_m_tready))
        else $error("input stalled with an empty stage");

    // a failed motion read gives zero acceleration, rate and temperature
    a_motion_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[191:0] == '0 && o_m_tdata[319:288] == '0))
        else $error("motion fields not zero while invalid");

    // an invalid magnetometer group gives zero field
    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[1]) |-> (o_m_tdata[287:192] == '0))
        else $error("field not zero while invalid");

    // an overflow word in an accepted frame clears the field flag
    a_mag_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && ($signed(i_s_tdata[127:112]) == MAG_OVF
            || $signed(i_s_tdata[143:128]) == MAG_OVF
            || $signed(i_s_tdata[159:144]) == MAG_OVF)) |=> !r_fok1)
        else $error("overflow frame kept field valid");
`endif

endmodule

### tb/sv/tb_imu_sample_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_sample_calibrator
// Streams raw IMU frames into the calibrator and compares every calibrated
// frame against a fixed-point model kept in the bench. A short table of
// corner frames runs first, then random frames under several gyro bias
// settings, with random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_imu_sample_calibrator;

    import isc_pkg::*;

    localparam int FRAC       = 16;
    localparam int COEF_FRAC  = 20;
    localparam int SC_FRAC    = 40;
    localparam int LATENCY    = 4;
    localparam int HOLD_CYCLES = 80;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [15:0]          FLD_OVERRANGE = 16'hf000;   // -4096

    // millionths to fixed point, nearest (positive inputs only)
    function automatic longint milli_q(input longint m, input int f);
        return (m * (64'sd1 <<< f) + 64'sd500000) / 64'sd1000000;
    endfunction

    localparam longint SC_ACC  = 64'sd1 <<< (SC_FRAC - 14);
    localparam longint SC_RATE = ((64'sd1 <<< SC_FRAC) + 64'sd65) / 64'sd131;
    localparam longint SC_TEMP = ((64'sd1 <<< SC_FRAC) + 64'sd170) / 64'sd340;
    localparam longint SC_FLD  = (64'sd73 * (64'sd1 <<< SC_FRAC) + 64'sd50) / 64'sd100;

    localparam longint ACC_BIAS_Q [3] = '{milli_q(19400, FRAC), -milli_q(8463, FRAC),
                                          -milli_q(98649, FRAC)};
    localparam longint ACC_GAIN_Q [9] = '{
        milli_q(991896, COEF_FRAC), milli_q(922, COEF_FRAC), -milli_q(2850, COEF_FRAC),
        milli_q(922, COEF_FRAC), milli_q(1004652, COEF_FRAC), -milli_q(2416, COEF_FRAC),
        -milli_q(2850, COEF_FRAC), -milli_q(2416, COEF_FRAC), milli_q(984773, COEF_FRAC)
    };
    localparam longint FLD_BIAS_Q [3] = '{-milli_q(187279956, FRAC),
                                          milli_q(7723305, FRAC), -milli_q(57187, FRAC)};
    localparam longint FLD_GAIN_Q [9] = '{
        milli_q(875656, COEF_FRAC), milli_q(27110, COEF_FRAC), -milli_q(54459, COEF_FRAC),
        milli_q(27110, COEF_FRAC), milli_q(891379, COEF_FRAC), milli_q(14806, COEF_FRAC),
        -milli_q(54459, COEF_FRAC), milli_q(14806, COEF_FRAC), milli_q(963926, COEF_FRAC)
    };
    localparam longint TEMP_BASE_Q = milli_q(36530000, FRAC);

    typedef struct packed {
        logic         known_zero;   // both groups off: every output field is zero
        logic [1:0]   ok;           // field_read_ok, motion_read_ok
        logic [159:0] words;        // tdata layout
    } t_stim_row;

    typedef struct packed {
        logic [319:0] data;
        logic [1:0]   flags;
    } t_calib_exp;

    // words listed high to low: field third, second, first, temp,
    // rate z, y, x, acc z, y, x
    localparam t_stim_row CORNER_FRAMES [17] = '{
        '{1'b1, 2'b00, {10{16'h0000}}},
        '{1'b1, 2'b00, {10{16'h7fff}}},
        '{1'b1, 2'b10, {16'h1234, 16'h0100, FLD_OVERRANGE, {7{16'h2222}}}},
        '{1'b0, 2'b11, {10{16'h0000}}},
        '{1'b0, 2'b11, {10{16'h7fff}}},
        '{1'b0, 2'b11, {10{16'h8000}}},
        '{1'b0, 2'b11, {10{16'hffff}}},
        '{1'b0, 2'b11, {10{16'h0001}}},
        '{1'b0, 2'b01, {{3{16'h4000}}, {7{16'h8000}}}},
        '{1'b0, 2'b10, {{3{16'h8000}}, {7{16'h7fff}}}},
        '{1'b0, 2'b11, {16'h0200, 16'h0300, FLD_OVERRANGE, {7{16'h1000}}}},
        '{1'b0, 2'b11, {16'h0200, FLD_OVERRANGE, 16'h0300, {7{16'h1000}}}},
        '{1'b0, 2'b11, {FLD_OVERRANGE, 16'h0300, 16'h0200, {7{16'h1000}}}},
        '{1'b0, 2'b11, {16'hf001, 16'hefff, 16'hf001, {7{16'hf000}}}},
        '{1'b0, 2'b11, {{5{16'h5555}}, {5{16'haaaa}}}},
        '{1'b0, 2'b11, {{5{16'haaaa}}, {5{16'h5555}}}},
        '{1'b0, 2'b11, {16'h0f00, 16'hff00, 16'h00f0, 16'h0b00, 16'hc000,
                        16'h4000, 16'h8000, 16'h2000, 16'he000, 16'h4000}}
    };

    string out_name [10] = '{"acc_x", "acc_y", "acc_z", "rate_x", "rate_y", "rate_z",
                             "field_x", "field_y", "field_z", "temperature"};
    string flag_name [2] = '{"motion_valid", "field_valid"};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [159:0]          i_s_tdata;
    logic [1:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [319:0]          o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [BIAS_W-1:0]     i_cfg_wdata;

    t_calib_exp pending_calib [$];
    longint     rate_bias [3];
    int         src_idle;
    int         snk_idle;
    bit         hold_req;
    int         frames_sent;
    int         frames_checked;
    int         bias_settings;
    int         errors;

    imu_sample_calibrator #(
        .FRAC_BITS      (FRAC),
        .COEF_FRAC_BITS (COEF_FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ---------------------------------------------------------------- model

    // round half up, floor shift
    function automatic longint round_up_shift(input longint x, input int k);
        return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint scale_count(input longint raw, input longint k);
        return round_up_shift(raw * k, SC_FRAC - FRAC);
    endfunction

    // scale, offset, saturate, then 3x3 gain; returns {z, y, x}
    function automatic logic [95:0] apply_cal(input longint raw [3], input longint k,
                                              input longint off [3], input longint gain [9]);
        longint      t [3];
        longint      sum;
        logic [95:0] res;
        int          i;
        for (i = 0; i < 3; i++) begin
            t[i] = $signed(clamp32(scale_count(raw[i], k) - off[i]));
        end
        for (i = 0; i < 3; i++) begin
            sum = gain[3*i] * t[0] + gain[3*i+1] * t[1] + gain[3*i+2] * t[2];
            res[32*i +: 32] = clamp32(round_up_shift(sum, COEF_FRAC));
        end
        return res;
    endfunction

    function automatic t_calib_exp calibrate_frame(input logic [159:0] words,
                                                   input logic [1:0] ok);
        longint     w [10];
        longint     grp [3];
        t_calib_exp e;
        int         i;
        for (i = 0; i < 10; i++) begin
            w[i] = $signed(words[16*i +: 16]);
        end
        e = '0;
        if (ok[0]) begin
            grp = '{w[0], w[1], w[2]};
            e.data[95:0] = apply_cal(grp, SC_ACC, ACC_BIAS_Q, ACC_GAIN_Q);
            for (i = 0; i < 3; i++) begin
                e.data[32*(3+i) +: 32] = clamp32(scale_count(w[3+i], SC_RATE) - rate_bias[i]);
            end
            e.data[319:288] = clamp32(scale_count(w[6], SC_TEMP) + TEMP_BASE_Q);
            e.flags[0] = 1'b1;
        end
        // magnetometer words arrive x, z, y; any overrange word kills the group
        if (ok[1] && words[127:112] != FLD_OVERRANGE && words[143:128] != FLD_OVERRANGE
                && words[159:144] != FLD_OVERRANGE) begin
            grp = '{w[7], w[9], w[8]};
            e.data[287:192] = apply_cal(grp, SC_FLD, FLD_BIAS_Q, FLD_GAIN_Q);
            e.flags[1] = 1'b1;
        end
        return e;
    endfunction

    // ------------------------------------------------------------ stimulus

    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_stim_row rand_frame();
        t_stim_row r;
        int        i;
        r.known_zero = 1'b0;
        for (i = 0; i < 10; i++) begin
            r.words[16*i +: 16] = rand_word();
        end
        r.ok = ($urandom_range(9) < 7) ? 2'b11 : 2'($urandom_range(3));
        if ($urandom_range(11) == 0) begin
            r.words[16*(7 + $urandom_range(2)) +: 16] = FLD_OVERRANGE;
        end
        return r;
    endfunction

    // call at a rising edge; returns at the edge where the frame is taken
    task automatic push_frame(input t_stim_row row);
        bit rdy;
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= row.words;
        i_s_tuser  <= row.ok;
        do begin
            @(negedge i_clk);
            rdy = o_s_tready;
            if (rdy) begin
                pending_calib.push_back(row.known_zero ? t_calib_exp'('0)
                                                       : calibrate_frame(row.words, row.ok));
                frames_sent++;
            end
            @(posedge i_clk);
        end while (!rdy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BIAS_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == REG_GYRO_BIAS_X || idx == REG_GYRO_BIAS_Y || idx == REG_GYRO_BIAS_Z) begin
            rate_bias[idx] = $signed(val);
        end
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_calib.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            push_frame(rand_frame());
        end
        i_s_tvalid <= 1'b0;
    endtask

    task automatic random_bias();
        int i;
        for (i = 0; i < 3; i++) begin
            write_reg(CFG_IDX_W'(i), BIAS_W'(int'($urandom_range(32768000)) - 16384000));
        end
        i_cfg_we <= 1'b0;
        bias_settings++;
    endtask

    // ------------------------------------------------------------- checking

    task automatic check_result(input logic [319:0] data, input logic [1:0] flags);
        t_calib_exp want;
        int         i;
        if (pending_calib.size() == 0) begin
            $display("%0t: calibrated frame with none pending: %h flags %b",
                     $time, data, flags);
            errors++;
            return;
        end
        want = pending_calib.pop_front();
        frames_checked++;
        for (i = 0; i < 10; i++) begin
            if (data[32*i +: 32] !== want.data[32*i +: 32]) begin
                $display("%0t: %s expected %0d got %0d", $time, out_name[i],
                         $signed(want.data[32*i +: 32]), $signed(data[32*i +: 32]));
                errors++;
            end
        end
        for (i = 0; i < 2; i++) begin
            if (flags[i] !== want.flags[i]) begin
                $display("%0t: %s expected %b got %b", $time, flag_name[i],
                         want.flags[i], flags[i]);
                errors++;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // output side: random stalls plus an on-demand long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // sample mid-cycle, score at the edge that completes the transaction
    initial begin
        logic [319:0] got_data;
        logic [1:0]   got_flags;
        bit           fire;
        forever begin
            @(negedge i_clk);
            fire      = i_rst_n && o_m_tvalid && i_m_tready;
            got_data  = o_m_tdata;
            got_flags = o_m_tuser;
            @(posedge i_clk);
            if (fire) begin
                check_result(got_data, got_flags);
            end
        end
    end

    initial begin
        #200000;
        $display("FAIL imu_sample_calibrator");
        $finish;
    end

    initial begin
        int i;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        rate_bias      = '{0, 0, 0};
        hold_req       = 1'b0;
        frames_sent    = 0;
        frames_checked = 0;
        bias_settings  = 1;
        errors         = 0;
        src_idle       = 23;
        snk_idle       = 88;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner frames with biases at reset
        for (i = 0; i < $size(CORNER_FRAMES); i++) begin
            push_frame(CORNER_FRAMES[i]);
        end
        i_s_tvalid <= 1'b0;
        wait_idle();

        // bias extremes; an unmapped index must change nothing
        write_reg(REG_GYRO_BIAS_X, 25'h0ffffff);
        write_reg(REG_GYRO_BIAS_Y, 25'h1000000);
        write_reg(REG_GYRO_BIAS_Z, 25'h1ffffff);
        write_reg(REG_UNUSED, 25'h0aaaaaa);
        i_cfg_we <= 1'b0;
        bias_settings++;
        send_random(140);
        wait_idle();

        random_bias();
        src_idle = 88;
        snk_idle = 23;
        send_random(130);
        wait_idle();

        write_reg(REG_GYRO_BIAS_X, BIAS_W'(-16384000));
        write_reg(REG_GYRO_BIAS_Y, BIAS_W'(16384000));
        write_reg(REG_GYRO_BIAS_Z, '0);
        i_cfg_we <= 1'b0;
        bias_settings++;
        src_idle = 0;
        snk_idle = 0;
        // hold the output off while frames keep coming, so the input backs up
        @(negedge i_clk);
        hold_req = 1'b1;
        @(posedge i_clk);
        send_random(40);
        wait_idle();

        random_bias();
        send_random(100);
        wait_idle();
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Checked %0d calibrated frames out of %0d raw frames under %0d bias settings.",
                 frames_checked, frames_sent, bias_settings);
        $display("Covered read failures, field overrange, stalls on both sides, %0d mismatches.",
                 errors);
        if (errors == 0 && pending_calib.size() == 0) begin
            $display("PASS imu_sample_calibrator");
        end else begin
            $display("FAIL imu_sample_calibrator");
        end
        $finish;
    end

endmodule
